// ===== rtl/uv_sphere_tessellator_top_assert.svh =====
// ----------------------------------------------------------------------------
// UV sphere tessellator assertion macros
// Implication and next-cycle checks shared by the RTL modules.
// ----------------------------------------------------------------------------
`ifndef UV_SPHERE_TESSELLATOR_TOP_ASSERT_SVH
`define UV_SPHERE_TESSELLATOR_TOP_ASSERT_SVH

// same-cycle implication
`define UVST_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define UVST_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/uvst_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere tessellator package
// Field widths, defaults, vertex slot order and fixed-point helpers.
// ----------------------------------------------------------------------------
package uvst_pkg;

   localparam int SUBDIV_DEFAULT      = 8;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam int ROW_W    = 4;
   localparam int COL_W    = 5;
   localparam int COORD_W  = 16;
   localparam int RADIUS_W = 15;
   localparam int SLOT_W   = 3;
   localparam int TRIG_W   = 15;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 15'd8192;
   localparam logic [SLOT_W-1:0]   FIRST_SLOT   = 3'd0;
   localparam logic [SLOT_W-1:0]   LAST_SLOT    = 3'd5;

   // corner codes of one quad
   localparam logic [1:0] PT_LO_J0 = 2'd0;
   localparam logic [1:0] PT_LO_J1 = 2'd1;
   localparam logic [1:0] PT_UP_J0 = 2'd2;
   localparam logic [1:0] PT_UP_J1 = 2'd3;

   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   localparam logic [63:0] TAYLOR_DIV [16] = '{
      64'd6,   64'd20,  64'd42,  64'd72,  64'd110, 64'd156, 64'd210, 64'd272,
      64'd342, 64'd420, 64'd506, 64'd600, 64'd702, 64'd812, 64'd930, 64'd1056
   };

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   // Q30 angle to Q14 sine, truncating Taylor series
   function automatic logic [TRIG_W-1:0] sin_taylor(logic [63:0] x);
      logic [63:0]        term;
      logic signed [63:0] sum;
      logic signed [63:0] rounded;
      term = x;
      sum  = '0;
      for (int n = 0; n < 16; n++) begin
         if (term != '0) begin
            if ((n & 1) != 0) begin
               sum = sum - $signed(term);
            end else begin
               sum = sum + $signed(term);
            end
            term = (term * x) >> 30;
            term = (term * x) >> 30;
            term = term / TAYLOR_DIV[n];
         end
      end
      if (sum < 0) begin
         sum = '0;
      end
      rounded = (sum + 64'sd32768) >>> 16;
      return TRIG_W'(rounded);
   endfunction

   function automatic logic [1:0] slot_point(logic [SLOT_W-1:0] slot);
      logic [1:0] pt;
      case (slot)
         3'd0:    pt = PT_LO_J0;
         3'd1:    pt = PT_UP_J1;
         3'd2:    pt = PT_UP_J0;
         3'd3:    pt = PT_LO_J0;
         3'd4:    pt = PT_LO_J1;
         3'd5:    pt = PT_UP_J1;
         default: pt = PT_LO_J0;
      endcase
      return pt;
   endfunction

   function automatic logic signed [COORD_W-1:0] apply_sign(logic neg,
                                                            logic [TRIG_W-1:0] mag);
      logic signed [COORD_W-1:0] v;
      v = $signed({1'b0, mag});
      return neg ? -v : v;
   endfunction

   // divide by 2^14, round half away from zero
   function automatic logic signed [17:0] rnd14(logic signed [31:0] v);
      logic [31:0] mag;
      logic [17:0] q;
      mag = (v < 0) ? 32'(-v) : 32'(v);
      q   = 18'((mag + 32'd8192) >> 14);
      return (v < 0) ? -$signed(q) : $signed(q);
   endfunction

endpackage

// ===== rtl/uvst_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere tessellator front end
// Accepts a quad request and resolves its ring and segment angle indices.
// ----------------------------------------------------------------------------
module uvst_front #(
   parameter  int SUBDIV = uvst_pkg::SUBDIV_DEFAULT,
   localparam int AW     = $clog2(4 * SUBDIV)
) (
   input  logic                          start,
   output logic                          busy,
   input  logic [uvst_pkg::ROW_W-1:0]    req_band_row,
   input  logic [uvst_pkg::COL_W-1:0]    req_segment_col,
   input  uvst_pkg::q_stat_type          stat,
   output logic                          push,
   output logic [4*AW-1:0]               entry
);

   localparam int FULL = 4 * SUBDIV;
   localparam int WW   = $clog2(4 * SUBDIV + 33);

   logic [AW-1:0] up;
   logic [AW-1:0] lo;
   logic [AW-1:0] j0;
   logic [AW-1:0] j1;

   function automatic logic [AW-1:0] wrap_full(logic [WW-1:0] v);
      logic [WW-1:0] w;
      w = v;
      for (int i = 0; i < 8; i++) begin
         if (w >= WW'(FULL)) begin
            w = w - WW'(FULL);
         end
      end
      return AW'(w);
   endfunction

   always_comb begin
      up = wrap_full(WW'(2 * SUBDIV) + WW'(req_band_row));
      lo = wrap_full(WW'(up) + WW'(1));
      j0 = wrap_full(WW'(req_segment_col));
      j1 = wrap_full(WW'(j0) + WW'(1));
   end

   assign busy  = stat.full;
   assign push  = start && !stat.full;
   assign entry = {up, lo, j0, j1};

endmodule

// ===== rtl/uvst_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere tessellator quad queue
// Short FIFO of resolved quads between front end and vertex engine.
// ----------------------------------------------------------------------------
`include "uv_sphere_tessellator_top_assert.svh"

module uvst_queue #(
   parameter int DEPTH = uvst_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int WIDTH = 20
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [WIDTH-1:0]     push_data,
   input  logic                 pop,
   output uvst_pkg::q_stat_type stat,
   output logic [WIDTH-1:0]     pop_data
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] entries_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign stat.full  = (count_ff == CW'(DEPTH));
   assign stat.empty = (count_ff == '0);
   assign pop_data   = entries_ff[rd_ptr_ff];

   `UVST_ASSERT_IMP(a_push_not_full, clock, reset, push, !stat.full, "push into full queue")
   `UVST_ASSERT_IMP(a_pop_not_empty, clock, reset, pop, !stat.empty, "pop from empty queue")
   `UVST_ASSERT_NXT(a_count_drop, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1, "queue count did not drop")

endmodule

// ===== rtl/uvst_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere tessellator vertex engine
// Steps six vertex slots per quad through a trig, multiply, scale pipeline.
// ----------------------------------------------------------------------------
`include "uv_sphere_tessellator_top_assert.svh"

module uvst_back #(
   parameter  int SUBDIV = uvst_pkg::SUBDIV_DEFAULT,
   localparam int AW     = $clog2(4 * SUBDIV)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  uvst_pkg::q_stat_type                 stat,
   input  logic [4*AW-1:0]                      pop_data,
   input  logic [uvst_pkg::RADIUS_W-1:0]        radius,
   output logic                                 pop,
   output logic                                 rsp_valid,
   output logic signed [uvst_pkg::COORD_W-1:0]  rsp_vx,
   output logic signed [uvst_pkg::COORD_W-1:0]  rsp_vy,
   output logic signed [uvst_pkg::COORD_W-1:0]  rsp_vz,
   output logic [uvst_pkg::SLOT_W-1:0]          rsp_vertex_slot,
   output logic                                 rsp_last_vertex
);

   localparam int CW = uvst_pkg::COORD_W;
   localparam int SW = uvst_pkg::SLOT_W;
   localparam int QW = $clog2(SUBDIV + 1);

   localparam logic [AW:0] S1 = (AW + 1)'(SUBDIV);
   localparam logic [AW:0] S2 = (AW + 1)'(2 * SUBDIV);
   localparam logic [AW:0] S3 = (AW + 1)'(3 * SUBDIV);
   localparam logic [AW:0] S4 = (AW + 1)'(4 * SUBDIV);

   // quarter-wave sine table
   logic [uvst_pkg::TRIG_W-1:0] sin_tab [SUBDIV + 1];

   for (genvar k = 0; k <= SUBDIV; k++) begin : g_sin
      localparam logic [63:0] XK = (64'(k) * uvst_pkg::PI_Q30) / (2 * SUBDIV);
      assign sin_tab[k] = uvst_pkg::sin_taylor(XK);
   end

   function automatic logic [QW:0] fold(logic [AW-1:0] k);
      logic [AW:0] kx;
      logic [AW:0] m;
      logic        neg;
      kx = {1'b0, k};
      if (kx < S1) begin
         neg = 1'b0;
         m   = kx;
      end else if (kx < S2) begin
         neg = 1'b0;
         m   = S2 - kx;
      end else if (kx < S3) begin
         neg = 1'b1;
         m   = kx - S2;
      end else begin
         neg = 1'b1;
         m   = S4 - kx;
      end
      return {neg, QW'(m)};
   endfunction

   function automatic logic [AW-1:0] quarter_on(logic [AW-1:0] k);
      logic [AW:0] s;
      s = {1'b0, k} + S1;
      if (s >= S4) begin
         s = s - S4;
      end
      return AW'(s);
   endfunction

   // sequencer
   logic          run_ff, run_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [4*AW-1:0] cur_ff, cur_in;
   logic          take;

   assign take = !stat.empty && (!run_ff || slot_ff == uvst_pkg::LAST_SLOT);
   assign pop  = take;

   always_comb begin
      run_in  = run_ff;
      slot_in = slot_ff;
      cur_in  = cur_ff;
      if (take) begin
         run_in  = 1'b1;
         slot_in = uvst_pkg::FIRST_SLOT;
         cur_in  = pop_data;
      end else if (run_ff && slot_ff == uvst_pkg::LAST_SLOT) begin
         run_in = 1'b0;
      end else if (run_ff) begin
         slot_in = slot_ff + 1'b1;
      end
   end

   // stage 0: corner select and table lookup
   logic [1:0]    pt;
   logic [AW-1:0] pol, azi;
   logic [QW:0]   f_sp, f_cp, f_sa, f_ca;

   logic          s1_valid_ff, s1_valid_in;
   logic [SW-1:0] s1_slot_ff, s1_slot_in;
   logic signed [CW-1:0] s1_sp_ff, s1_sp_in;
   logic signed [CW-1:0] s1_cp_ff, s1_cp_in;
   logic signed [CW-1:0] s1_sa_ff, s1_sa_in;
   logic signed [CW-1:0] s1_ca_ff, s1_ca_in;

   always_comb begin
      pt  = uvst_pkg::slot_point(slot_ff);
      pol = (pt == uvst_pkg::PT_UP_J0 || pt == uvst_pkg::PT_UP_J1) ?
            cur_ff[4*AW-1:3*AW] : cur_ff[3*AW-1:2*AW];
      azi = (pt == uvst_pkg::PT_LO_J1 || pt == uvst_pkg::PT_UP_J1) ?
            cur_ff[AW-1:0] : cur_ff[2*AW-1:AW];
      f_sp = fold(pol);
      f_cp = fold(quarter_on(pol));
      f_sa = fold(azi);
      f_ca = fold(quarter_on(azi));
      s1_valid_in = run_ff;
      s1_slot_in  = slot_ff;
      s1_sp_in    = uvst_pkg::apply_sign(f_sp[QW], sin_tab[f_sp[QW-1:0]]);
      s1_cp_in    = uvst_pkg::apply_sign(f_cp[QW], sin_tab[f_cp[QW-1:0]]);
      s1_sa_in    = uvst_pkg::apply_sign(f_sa[QW], sin_tab[f_sa[QW-1:0]]);
      s1_ca_in    = uvst_pkg::apply_sign(f_ca[QW], sin_tab[f_ca[QW-1:0]]);
   end

   // stage 1: direction products and y
   logic signed [CW-1:0] rad_s;
   logic signed [31:0]   p_x, p_z, p_y;

   logic          s2_valid_ff, s2_valid_in;
   logic [SW-1:0] s2_slot_ff, s2_slot_in;
   logic signed [CW-1:0] s2_tx_ff, s2_tx_in;
   logic signed [CW-1:0] s2_tz_ff, s2_tz_in;
   logic signed [CW-1:0] s2_y_ff, s2_y_in;

   assign rad_s = $signed({1'b0, radius});

   always_comb begin
      p_x = s1_ca_ff * s1_sp_ff;
      p_z = s1_sa_ff * s1_sp_ff;
      p_y = rad_s * s1_cp_ff;
      s2_valid_in = s1_valid_ff;
      s2_slot_in  = s1_slot_ff;
      s2_tx_in    = CW'(uvst_pkg::rnd14(p_x));
      s2_tz_in    = CW'(uvst_pkg::rnd14(p_z));
      s2_y_in     = CW'(uvst_pkg::rnd14(p_y));
   end

   // stage 2: radius scale into the output register
   logic signed [31:0] q_x, q_z;

   logic          s3_valid_ff, s3_valid_in;
   logic [SW-1:0] s3_slot_ff, s3_slot_in;
   logic signed [CW-1:0] s3_vx_ff, s3_vx_in;
   logic signed [CW-1:0] s3_vy_ff, s3_vy_in;
   logic signed [CW-1:0] s3_vz_ff, s3_vz_in;

   always_comb begin
      q_x = rad_s * s2_tx_ff;
      q_z = rad_s * s2_tz_ff;
      s3_valid_in = s2_valid_ff;
      s3_slot_in  = s2_slot_ff;
      s3_vx_in    = CW'(uvst_pkg::rnd14(q_x));
      s3_vy_in    = s2_y_ff;
      s3_vz_in    = CW'(uvst_pkg::rnd14(q_z));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff      <= 1'b0;
         slot_ff     <= uvst_pkg::FIRST_SLOT;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         run_ff      <= run_in;
         slot_ff     <= slot_in;
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      s1_slot_ff <= s1_slot_in;
      s1_sp_ff   <= s1_sp_in;
      s1_cp_ff   <= s1_cp_in;
      s1_sa_ff   <= s1_sa_in;
      s1_ca_ff   <= s1_ca_in;
      s2_slot_ff <= s2_slot_in;
      s2_tx_ff   <= s2_tx_in;
      s2_tz_ff   <= s2_tz_in;
      s2_y_ff    <= s2_y_in;
      s3_slot_ff <= s3_slot_in;
      s3_vx_ff   <= s3_vx_in;
      s3_vy_ff   <= s3_vy_in;
      s3_vz_ff   <= s3_vz_in;
   end

   assign rsp_valid       = s3_valid_ff;
   assign rsp_vx          = s3_vx_ff;
   assign rsp_vy          = s3_vy_ff;
   assign rsp_vz          = s3_vz_ff;
   assign rsp_vertex_slot = s3_slot_ff;
   assign rsp_last_vertex = (s3_slot_ff == uvst_pkg::LAST_SLOT);

   `UVST_ASSERT_NXT(a_slot_step, clock, reset, s3_valid_ff && s3_slot_ff != uvst_pkg::LAST_SLOT, s3_valid_ff && s3_slot_ff == $past(s3_slot_ff) + 1'b1, "vertex slots not consecutive")

endmodule

// ===== rtl/uv_sphere_tessellator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV sphere tessellator
// Emits the six triangle vertices of one UV sphere quad per request.
// ----------------------------------------------------------------------------
// Channel    Ports                                      Beat taken when
// request    req_band_row, req_segment_col              start && !busy
// response   rsp_vx/vy/vz, rsp_vertex_slot, rsp_last    rsp_valid (one cycle)
// config     csr_wr_data (radius)                       csr_wr_en
//
// One request yields six response beats on consecutive cycles; the vertex
// engine steps one slot per cycle, so queued quads follow without a gap.
// Each vertex passes the lookup, product and scale registers to the outputs.
// busy rises while the quad queue holds QUEUE_DEPTH requests.
// Reset is synchronous; radius returns to 0.5 and the queue empties.
// ----------------------------------------------------------------------------
module uv_sphere_tessellator_top #(
   parameter int SUBDIV      = uvst_pkg::SUBDIV_DEFAULT,
   parameter int QUEUE_DEPTH = uvst_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [uvst_pkg::ROW_W-1:0]           req_band_row,
   input  logic [uvst_pkg::COL_W-1:0]           req_segment_col,
   output logic                                 rsp_valid,
   output logic signed [uvst_pkg::COORD_W-1:0]  rsp_vx,
   output logic signed [uvst_pkg::COORD_W-1:0]  rsp_vy,
   output logic signed [uvst_pkg::COORD_W-1:0]  rsp_vz,
   output logic [uvst_pkg::SLOT_W-1:0]          rsp_vertex_slot,
   output logic                                 rsp_last_vertex,
   input  logic                                 csr_wr_en,
   input  logic [uvst_pkg::RADIUS_W-1:0]        csr_wr_data
);

   localparam int AW = $clog2(4 * SUBDIV);

   logic [uvst_pkg::RADIUS_W-1:0] radius_ff, radius_in;
   uvst_pkg::q_stat_type          stat;
   logic                          push;
   logic                          pop;
   logic [4*AW-1:0]               push_data;
   logic [4*AW-1:0]               pop_data;

   assign radius_in = csr_wr_en ? csr_wr_data : radius_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= uvst_pkg::RADIUS_RESET;
      end else begin
         radius_ff <= radius_in;
      end
   end

   uvst_front #(
      .SUBDIV (SUBDIV)
   ) u_front (
      .start           (start),
      .busy            (busy),
      .req_band_row    (req_band_row),
      .req_segment_col (req_segment_col),
      .stat            (stat),
      .push            (push),
      .entry           (push_data)
   );

   uvst_queue #(
      .DEPTH (QUEUE_DEPTH),
      .WIDTH (4 * AW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .stat      (stat),
      .pop_data  (pop_data)
   );

   uvst_back #(
      .SUBDIV (SUBDIV)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .stat            (stat),
      .pop_data        (pop_data),
      .radius          (radius_ff),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_vx          (rsp_vx),
      .rsp_vy          (rsp_vy),
      .rsp_vz          (rsp_vz),
      .rsp_vertex_slot (rsp_vertex_slot),
      .rsp_last_vertex (rsp_last_vertex)
   );

endmodule
